// ----- rtl/e2r_pkg.sv -----
// ----------------------------------------------------------------------------
// e2r_pkg
// Shared types, constants and the arctangent table for the Euler-angle block.
// ----------------------------------------------------------------------------
package e2r_pkg;

  localparam int AngleWidth  = 16;
  localparam int EntryWidth  = 16;
  localparam int CordicWidth = 34;   // Q.30 plus sign and growth
  localparam int TrigWidth   = 22;   // Q.20 sine/cosine, |v| <= 2^20
  localparam int ProdWidth   = 44;   // Q.40 products and sums
  localparam int AtanLen     = 24;
  localparam int StagesDefault = 16;

  localparam logic signed [CordicWidth-1:0] HalfPi = 34'sd1686629713;
  localparam logic signed [CordicWidth-1:0] AnglePi = 34'sd3373259426;
  localparam logic signed [CordicWidth-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [ProdWidth-1:0] EntryOne = 44'sd16384;

  typedef logic signed [AngleWidth-1:0]  angle_t;
  typedef logic signed [EntryWidth-1:0]  entry_t;
  typedef logic signed [CordicWidth-1:0] cordic_t;
  typedef logic signed [TrigWidth-1:0]   trig_t;
  typedef logic signed [ProdWidth-1:0]   prod_t;

  typedef struct packed {
    cordic_t x;
    cordic_t y;
    cordic_t z;
    logic    flip;
  } rot_t;

  typedef struct packed {
    trig_t sin_v;
    trig_t cos_v;
  } sc_t;

  function automatic cordic_t atan_entry(input int i);
    cordic_t r;
    r = '0;
    case (i)
      0: r = 34'sd843314856;   1: r = 34'sd497837829;
      2: r = 34'sd263043836;   3: r = 34'sd133525158;
      4: r = 34'sd67021686;    5: r = 34'sd33543515;
      6: r = 34'sd16775850;    7: r = 34'sd8388437;
      8: r = 34'sd4194282;     9: r = 34'sd2097149;
      10: r = 34'sd1048575;    11: r = 34'sd524287;
      12: r = 34'sd262143;     13: r = 34'sd131071;
      14: r = 34'sd65535;      15: r = 34'sd32767;
      16: r = 34'sd16383;      17: r = 34'sd8191;
      18: r = 34'sd4095;       19: r = 34'sd2047;
      20: r = 34'sd1023;       21: r = 34'sd511;
      22: r = 34'sd255;        23: r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Round Q.40 to Q.20 (add half, floor).
  function automatic trig_t round20(input prod_t v);
    prod_t t;
    t = (v + (prod_t'(1) <<< 19)) >>> 20;
    return t[TrigWidth-1:0];
  endfunction

  // Round Q.40 to Q1.14 and clamp to +-1.0.
  function automatic entry_t to_entry(input prod_t v);
    prod_t r;
    r = (v + (prod_t'(1) <<< 25)) >>> 26;
    if (r > EntryOne) r = EntryOne;
    if (r < -EntryOne) r = -EntryOne;
    return r[EntryWidth-1:0];
  endfunction

endpackage

// ----- rtl/e2r_if.sv -----
// ----------------------------------------------------------------------------
// e2r_in_if / e2r_out_if
// Valid/ready channels carrying the angle triple and the matrix entries.
// ----------------------------------------------------------------------------
interface e2r_in_if;
  import e2r_pkg::*;
  logic   valid;
  logic   ready;
  angle_t roll_angle;
  angle_t pitch_angle;
  angle_t yaw_angle;
  modport source (output valid, output roll_angle, output pitch_angle,
                  output yaw_angle, input ready);
  modport sink (input valid, input roll_angle, input pitch_angle,
                input yaw_angle, output ready);
endinterface

interface e2r_out_if;
  import e2r_pkg::*;
  logic   valid;
  logic   ready;
  entry_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source (output valid, output m00, output m01, output m02, output m10,
                  output m11, output m12, output m20, output m21, output m22,
                  input ready);
  modport sink (input valid, input m00, input m01, input m02, input m10,
                input m11, input m12, input m20, input m21, input m22,
                output ready);
endinterface

// ----- rtl/euler_to_rotation_matrix.sv -----
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix
// Roll/pitch/yaw (Q2.13 rad) to the Z-Y-X rotation matrix (Q1.14, saturated).
// ----------------------------------------------------------------------------
// Fully pipelined: one transfer per cycle in and out while the output is not
// stalled. The pipe holds one fold register, one CORDIC cell per stage
// (the three angles share each cell in parallel lanes), one rounding
// register and three product/rounding registers. The whole pipe advances
// while the output register is empty or being taken; a stall at the output
// holds every stage, so ready follows the output side combinationally.
module euler_to_rotation_matrix #(
  parameter int CORDIC_STAGES = e2r_pkg::StagesDefault
) (
  input logic clk,
  input logic rst,
  e2r_in_if.sink    in_ch,
  e2r_out_if.source out_ch
);
  import e2r_pkg::*;

  localparam int NStages = (CORDIC_STAGES > AtanLen) ? AtanLen : CORDIC_STAGES;
  localparam int Depth = NStages + 5;

  logic [Depth-1:0] vld;
  logic en;

  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;
  assign out_ch.valid = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Depth-2:0], in_ch.valid};
    end
  end

  // fold into [-pi/2, pi/2]
  rot_t chain [NStages+1][3];
  angle_t ang [3];
  assign ang[0] = in_ch.roll_angle;
  assign ang[1] = in_ch.pitch_angle;
  assign ang[2] = in_ch.yaw_angle;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        cordic_t z;
        z = cordic_t'(ang[k]) <<< 17;
        chain[0][k].x <= CordicGain;
        chain[0][k].y <= '0;
        if (z > HalfPi) begin
          chain[0][k].z <= AnglePi - z;
          chain[0][k].flip <= 1'b1;
        end else if (z < -HalfPi) begin
          chain[0][k].z <= -AnglePi - z;
          chain[0][k].flip <= 1'b1;
        end else begin
          chain[0][k].z <= z;
          chain[0][k].flip <= 1'b0;
        end
      end
    end
  end

  for (genvar i = 0; i < NStages; i++) begin : g_cell
    e2r_cordic_cell #(.STAGE(i)) u_cell (
      .clk (clk),
      .en  (en),
      .din (chain[i]),
      .dout(chain[i+1])
    );
  end

  sc_t sc [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        cordic_t xv;
        cordic_t sr;
        cordic_t cr;
        xv = chain[NStages][k].flip ? -chain[NStages][k].x : chain[NStages][k].x;
        sr = (chain[NStages][k].y + cordic_t'(512)) >>> 10;
        cr = (xv + cordic_t'(512)) >>> 10;
        sc[k].sin_v <= sr[TrigWidth-1:0];
        sc[k].cos_v <= cr[TrigWidth-1:0];
      end
    end
  end

  entry_t ent [9];
  e2r_matrix u_matrix (
    .clk (clk),
    .en  (en),
    .sc_x(sc[0]),
    .sc_y(sc[1]),
    .sc_z(sc[2]),
    .ent (ent)
  );

  assign out_ch.m00 = ent[0];
  assign out_ch.m01 = ent[1];
  assign out_ch.m02 = ent[2];
  assign out_ch.m10 = ent[3];
  assign out_ch.m11 = ent[4];
  assign out_ch.m12 = ent[5];
  assign out_ch.m20 = ent[6];
  assign out_ch.m21 = ent[7];
  assign out_ch.m22 = ent[8];
endmodule

// ----- rtl/e2r_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// e2r_cordic_cell
// One CORDIC micro-rotation for three angles; registers its result.
// ----------------------------------------------------------------------------
module e2r_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic         clk,
  input  logic         en,
  input  e2r_pkg::rot_t din [3],
  output e2r_pkg::rot_t dout [3]
);
  import e2r_pkg::*;

  localparam cordic_t AtanVal = atan_entry(STAGE);

  rot_t nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nxt[k].flip = din[k].flip;
      if (din[k].z >= 0) begin
        nxt[k].x = din[k].x - (din[k].y >>> STAGE);
        nxt[k].y = din[k].y + (din[k].x >>> STAGE);
        nxt[k].z = din[k].z - AtanVal;
      end else begin
        nxt[k].x = din[k].x + (din[k].y >>> STAGE);
        nxt[k].y = din[k].y - (din[k].x >>> STAGE);
        nxt[k].z = din[k].z + AtanVal;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) dout <= nxt;
  end
endmodule

// ----- rtl/e2r_matrix.sv -----
// ----------------------------------------------------------------------------
// e2r_matrix
// Three-stage product network from sines/cosines to the nine entries.
// ----------------------------------------------------------------------------
module e2r_matrix (
  input  logic          clk,
  input  logic          en,
  input  e2r_pkg::sc_t  sc_x,
  input  e2r_pkg::sc_t  sc_y,
  input  e2r_pkg::sc_t  sc_z,
  output e2r_pkg::entry_t ent [9]
);
  import e2r_pkg::*;

  // stage 1: two-factor products
  prod_t czcy, szcy, cysx, cycx, czsy, szsy, szcx, szsx, czcx, czsx;
  trig_t sx1, cx1, sy1;
  // stage 2: rounded pairs times third factor
  prod_t p01, p02, p11, p12;
  prod_t a00, a10, a20, a21, a22, b01, b02, b11, b12;

  always_ff @(posedge clk) begin
    if (en) begin
      czcy <= prod_t'(sc_z.cos_v) * prod_t'(sc_y.cos_v);
      szcy <= prod_t'(sc_z.sin_v) * prod_t'(sc_y.cos_v);
      cysx <= prod_t'(sc_y.cos_v) * prod_t'(sc_x.sin_v);
      cycx <= prod_t'(sc_y.cos_v) * prod_t'(sc_x.cos_v);
      czsy <= prod_t'(sc_z.cos_v) * prod_t'(sc_y.sin_v);
      szsy <= prod_t'(sc_z.sin_v) * prod_t'(sc_y.sin_v);
      szcx <= prod_t'(sc_z.sin_v) * prod_t'(sc_x.cos_v);
      szsx <= prod_t'(sc_z.sin_v) * prod_t'(sc_x.sin_v);
      czcx <= prod_t'(sc_z.cos_v) * prod_t'(sc_x.cos_v);
      czsx <= prod_t'(sc_z.cos_v) * prod_t'(sc_x.sin_v);
      sx1  <= sc_x.sin_v;
      cx1  <= sc_x.cos_v;
      sy1  <= sc_y.sin_v;

      p01 <= prod_t'(round20(czsy)) * prod_t'(sx1);
      p02 <= prod_t'(round20(czsy)) * prod_t'(cx1);
      p11 <= prod_t'(round20(szsy)) * prod_t'(sx1);
      p12 <= prod_t'(round20(szsy)) * prod_t'(cx1);
      b01 <= szcx;
      b02 <= szsx;
      b11 <= czcx;
      b12 <= czsx;
      a00 <= czcy;
      a10 <= szcy;
      a20 <= -(prod_t'(sy1) <<< 20);
      a21 <= cysx;
      a22 <= cycx;

      ent[0] <= to_entry(a00);
      ent[1] <= to_entry(p01 - b01);
      ent[2] <= to_entry(p02 + b02);
      ent[3] <= to_entry(a10);
      ent[4] <= to_entry(p11 + b11);
      ent[5] <= to_entry(p12 - b12);
      ent[6] <= to_entry(a20);
      ent[7] <= to_entry(a21);
      ent[8] <= to_entry(a22);
    end
  end
endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Checks the Euler-angle to rotation-matrix block against a bit-exact
// predictor. Angles come in bursts with random gaps, the output side stalls
// on its own pattern, and one long output hold-off fills the pipe.
// ----------------------------------------------------------------------------
module tb;
  import e2r_pkg::*;

  typedef struct packed {
    entry_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } matrix_t;

  // Sine and cosine of a Q2.13 angle, both in Q.20.
  function automatic void trig_of(input angle_t ang, output longint s, output longint c);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'(ang) * 131072;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 64'sd1686629713) begin
      z = 64'sd3373259426 - z;
      flip = 1;
    end else if (z < -64'sd1686629713) begin
      z = -64'sd3373259426 - z;
      flip = 1;
    end
    for (int i = 0; i < StagesDefault && i < AtanLen; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(atan_entry(i));
      end else begin
        x += dx;
        y -= dy;
        z += longint'(atan_entry(i));
      end
    end
    if (flip) x = -x;
    s = (y + 512) >>> 10;
    c = (x + 512) >>> 10;
  endfunction

  function automatic entry_t clamp_entry(input longint v);
    longint r;
    r = (v + (64'sd1 <<< 25)) >>> 26;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return entry_t'(r);
  endfunction

  function automatic longint triple(input longint a, input longint b, input longint c);
    return ((a * b + (64'sd1 <<< 19)) >>> 20) * c;
  endfunction

  function automatic matrix_t rotation_of(input angle_t roll, input angle_t pitch,
                                          input angle_t yaw);
    longint sx, cx, sy, cy, sz, cz;
    matrix_t m;
    trig_of(roll, sx, cx);
    trig_of(pitch, sy, cy);
    trig_of(yaw, sz, cz);
    m.m00 = clamp_entry(cz * cy);
    m.m01 = clamp_entry(triple(cz, sy, sx) - sz * cx);
    m.m02 = clamp_entry(triple(cz, sy, cx) + sz * sx);
    m.m10 = clamp_entry(sz * cy);
    m.m11 = clamp_entry(triple(sz, sy, sx) + cz * cx);
    m.m12 = clamp_entry(triple(sz, sy, cx) - cz * sx);
    m.m20 = clamp_entry(-(sy * 1048576));
    m.m21 = clamp_entry(cy * sx);
    m.m22 = clamp_entry(cy * cx);
    return m;
  endfunction

  class matrix_board;
    matrix_t pending[$];
    int errors = 0;

    function void note_angles(angle_t roll, angle_t pitch, angle_t yaw);
      pending.push_back(rotation_of(roll, pitch, yaw));
    endfunction

    function void check_matrix(matrix_t got);
      matrix_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected matrix %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      for (int k = 0; k < 9; k++) begin
        if (want[k*16 +: 16] !== got[k*16 +: 16]) begin
          $display("%0t: entry %0d expected %0d actual %0d", $time, 8 - k,
                   $signed(want[k*16 +: 16]), $signed(got[k*16 +: 16]));
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  e2r_in_if in_ch ();
  e2r_out_if out_ch ();
  matrix_board board = new();
  bit sent_all = 0;
  bit hold_out = 0;
  longint cycles = 0;

  euler_to_rotation_matrix i_dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  initial forever #4 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.roll_angle = '0;
    in_ch.pitch_angle = '0;
    in_ch.yaw_angle = '0;
    out_ch.ready = 0;
  end

  // Note accepted angles and check matrices at the rising edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && in_ch.valid && in_ch.ready)
      board.note_angles(in_ch.roll_angle, in_ch.pitch_angle, in_ch.yaw_angle);
    if (!rst && out_ch.valid && out_ch.ready)
      board.check_matrix({out_ch.m00, out_ch.m01, out_ch.m02, out_ch.m10, out_ch.m11,
                          out_ch.m12, out_ch.m20, out_ch.m21, out_ch.m22});
    if (cycles > 200000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Output stall pattern; hold_out forces a long stall.
  always @(negedge clk) begin
    if (hold_out) out_ch.ready <= 0;
    else if (cycles % 600 < 200) out_ch.ready <= 1;
    else out_ch.ready <= ($urandom_range(3) != 0);
  end

  initial begin
    @(negedge clk);
    hold_out = 1;
    repeat (300) @(negedge clk);
    hold_out = 0;
  end

  task automatic send_angles(input angle_t roll, input angle_t pitch, input angle_t yaw);
    in_ch.valid <= 1;
    in_ch.roll_angle <= roll;
    in_ch.pitch_angle <= pitch;
    in_ch.yaw_angle <= yaw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic angle_t pick_angle();
    case ($urandom_range(5))
      0: return angle_t'($urandom_range(65535));
      1: return angle_t'($urandom_range(12868) - 6434);   // within +-pi/4 region
      2: return angle_t'(($urandom_range(1) ? 12868 : -12868) + $urandom_range(8) - 4);
      3: return angle_t'(($urandom_range(1) ? 25736 : -25736) + $urandom_range(8) - 4);
      default: return angle_t'($urandom_range(51472) - 25736);
    endcase
  endfunction

  initial begin
    angle_t edges[9];
    int burst;
    edges = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001,
              16'sd12868, -16'sd12868, 16'sd25736, -16'sd25736};
    repeat (10) @(posedge clk);
    rst <= 0;
    @(negedge clk);
    for (int k = 0; k < 9; k++) begin
      send_angles(edges[k], edges[(k + 3) % 9], edges[(k + 6) % 9]);
      send_angles(edges[(k + 5) % 9], edges[k], edges[(k + 1) % 9]);
    end
    for (int n = 0; n < 1900; ) begin
      burst = $urandom_range(40, 1);
      for (int b = 0; b < burst; b++, n++)
        send_angles(pick_angle(), pick_angle(), pick_angle());
      if ($urandom_range(2) != 0) begin
        in_ch.valid <= 0;
        repeat ($urandom_range(12, 1)) @(negedge clk);
      end
    end
    in_ch.valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (StagesDefault + 20) @(negedge clk);
    if (board.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
